/* hw/rtl/assert_macros.svh */
// assertion macros for the factorial and binomial unit
// included by the files that carry concurrent assertions; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked on every rising edge outside reset
`define FBU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define FBU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FBU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define FBU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* hw/rtl/fbu_pkg.sv */
// shared types and constants of the factorial and binomial unit
// no dependencies; imported by the channel interfaces and all modules
package fbu_pkg;

  localparam int ARG_W    = 8;                // width of n, k and loop counters
  localparam int VALUE_W  = 64;               // width of the result value
  localparam int STATUS_W = 2;
  localparam int PROD_W   = VALUE_W + ARG_W;  // accumulator times one argument
  localparam int CNT_W    = $clog2(PROD_W);   // divider step counter

  // operation codes
  localparam logic CMD_FACT  = 1'b0;
  localparam logic CMD_BINOM = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // request into the shared multiply-divide unit
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] acc;
    logic [ARG_W-1:0]   x;
    logic [ARG_W-1:0]   d;
  } md_req_t;

  // answer from the shared multiply-divide unit
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quo;
  } md_rsp_t;

endpackage

/* hw/rtl/fbu_in_if.sv */
// input channel of the factorial and binomial unit: command, n and k
// depends on fbu_pkg
interface fbu_in_if
  import fbu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [ARG_W-1:0] n;
  logic [ARG_W-1:0] k;

  modport source (output valid, output cmd, output n, output k, input ready);
  modport sink (input valid, input cmd, input n, input k, output ready);
endinterface

/* hw/rtl/fbu_out_if.sv */
// result channel of the factorial and binomial unit: value and status
// depends on fbu_pkg
interface fbu_out_if
  import fbu_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

/* hw/rtl/fbu_mul_div.sv */
// shared multiply-divide unit: a multiply on start, then a restoring divider
// that retires one quotient bit per cycle; depends on fbu_pkg
module fbu_mul_div
  import fbu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  logic [PROD_W-1:0] prod;     // product, shifted out while quotient shifts in
  logic [ARG_W-1:0]  rem;
  logic [ARG_W-1:0]  dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [ARG_W:0]    trial;
  logic              qbit;
  logic [ARG_W:0]    trial_sub;

  // one restoring step: bring down the next product bit, try the divisor
  always_comb begin
    trial     = {rem, prod[PROD_W-1]};
    qbit      = (trial >= {1'b0, dvs});
    trial_sub = trial - {1'b0, dvs};
  end

  // control: busy over the division steps, done for one cycle at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: multiply on start, then shift and subtract
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= PROD_W'(req.acc) * PROD_W'(req.x);
      rem  <= '0;
      dvs  <= req.d;
      cnt  <= CNT_W'(PROD_W - 1);
    end else if (busy) begin
      prod <= {prod[PROD_W-2:0], qbit};
      rem  <= qbit ? trial_sub[ARG_W-1:0] : trial[ARG_W-1:0];
      cnt  <= cnt - 1'b1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = prod;

endmodule

/* hw/rtl/factorial_binomial_unit.sv */
// top level of the factorial and binomial unit: sequencer and result register
// depends on fbu_pkg, fbu_in_if, fbu_out_if, fbu_mul_div and assert_macros.svh
//
//   channel  dir  fields                 transfer when
//   req      in   cmd, n[7:0], k[7:0]    req.valid && req.ready
//   rsp      out  value[63:0], status    rsp.valid && rsp.ready
//
// each loop step: S_ISSUE starts fbu_mul_div, which forms the product,
// then S_WAIT holds while its bit-serial divider runs, and the step retires on done
// factorial runs n - 1 steps, binomial min(k, n - k) steps; overflow ends early
// trivial cases (n below 2, k above n, k equal to 0 or n) skip the loop and go to S_DONE
// rst is synchronous; req.ready is high only while the sequencer is idle and out of reset
// a result waiting on rsp holds the sequencer before it loads the next one
`include "assert_macros.svh"

module factorial_binomial_unit
  import fbu_pkg::*;
#(
  parameter int N_BITS      = 8,
  parameter int RESULT_BITS = 64
) (
  input logic      clk,
  input logic      rst,
  fbu_in_if.sink   req,
  fbu_out_if.source rsp
);

  localparam int ARG_USED = (N_BITS < ARG_W) ? N_BITS : ARG_W;
  localparam logic [ARG_W:0] ARG_MASK_W = (ARG_W + 1)'((1 << ARG_USED) - 1);
  localparam logic [ARG_W-1:0] ARG_MASK = ARG_MASK_W[ARG_W-1:0];

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state;
  logic [VALUE_W-1:0] acc;
  logic [ARG_W-1:0]   idx;
  logic [ARG_W-1:0]   last;
  logic [ARG_W-1:0]   big;
  logic               mode;
  status_t            st;

  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  status_t             out_status;

  logic [ARG_W-1:0] n_m;
  logic [ARG_W-1:0] k_m;
  logic [ARG_W-1:0] diff;
  logic             accept;
  logic             ovf;

  md_req_t md_req;
  md_rsp_t md_rsp;

  fbu_mul_div u_mul_div (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // argument masking and the smaller/larger split for binomial
  always_comb begin
    n_m    = req.n & ARG_MASK;
    k_m    = req.k & ARG_MASK;
    diff   = n_m - k_m;
    accept = req.valid && req.ready;
    ovf    = (md_rsp.quo >> RESULT_BITS) != '0;
  end

  assign req.ready = (state == S_IDLE) && !rst;

  // issue one step: factorial multiplies by i, binomial by big + i over i
  always_comb begin
    md_req.start = (state == S_ISSUE);
    md_req.acc   = acc;
    md_req.x     = (mode == CMD_FACT) ? idx : ARG_W'(big + idx);
    md_req.d     = (mode == CMD_FACT) ? ARG_W'(1) : idx;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.cmd == CMD_FACT) begin
              state <= (n_m < ARG_W'(2)) ? S_DONE : S_ISSUE;
            end else if (k_m > n_m) begin
              state <= S_DONE;
            end else if ((k_m == '0) || (diff == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (md_rsp.done) begin
            state <= (ovf || (idx == last)) ? S_DONE : S_ISSUE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // loop registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          acc  <= VALUE_W'(1);
          mode <= req.cmd;
          st   <= ST_OK;
          if (req.cmd == CMD_FACT) begin
            idx  <= ARG_W'(2);
            last <= n_m;
            big  <= '0;
          end else begin
            idx  <= ARG_W'(1);
            last <= (diff > k_m) ? k_m : diff;
            big  <= (diff > k_m) ? diff : k_m;
            if (k_m > n_m) begin
              acc <= '0;
              st  <= ST_INVALID;
            end
          end
        end
      end
      S_WAIT: begin
        if (md_rsp.done) begin
          if (ovf) begin
            acc <= '0;
            st  <= ST_OVERFLOW;
          end else begin
            acc <= md_rsp.quo[VALUE_W-1:0];
            idx <= idx + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result register; loaded once the previous result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_value  <= acc;
      out_status <= st;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.value  = out_value;
  assign rsp.status = out_status;

  // checks
  `FBU_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !req.ready, "ready after accept")
  `FBU_ASSERT_SAME(a_zero_on_error, clk, rst, rsp.valid && (rsp.status != ST_OK), rsp.value == '0, "nonzero value with error status")
  `FBU_ASSERT_SAME(a_done_in_wait, clk, rst, md_rsp.done, state == S_WAIT, "divider done outside wait")
  `FBU_ASSERT_SAME(a_issue_idle_unit, clk, rst, md_req.start, !md_rsp.busy, "step issued while divider busy")

endmodule

/* bench/factorial_binomial_unit_tb.sv */
// self-checking testbench for factorial_binomial_unit: factorial and n choose k requests
// depends on fbu_pkg, fbu_in_if, fbu_out_if and the rtl of factorial_binomial_unit
module factorial_binomial_unit_tb;
  import fbu_pkg::*;

  localparam int          WIDE_W       = 2 * VALUE_W;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned DRAIN_CYCLES = 3000;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;

  // one request together with the answer it should produce
  typedef struct packed {
    logic               cmd;
    logic [ARG_W-1:0]   n;
    logic [ARG_W-1:0]   k;
    logic [VALUE_W-1:0] value;
    status_t            status;
  } answer_t;

  logic clk = 1'b0;
  logic rst;

  fbu_in_if  req_ch ();
  fbu_out_if rsp_ch ();

  factorial_binomial_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  answer_t     pending_answers[$];
  answer_t     oldest_answer;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_done     = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  // exact factorial or multiplicative binomial at 64 bits, wide products
  function automatic answer_t predict_answer(input logic cmd, input logic [ARG_W-1:0] n,
                                             input logic [ARG_W-1:0] k);
    answer_t            ans;
    logic [WIDE_W-1:0]  prod;
    logic [VALUE_W-1:0] acc;
    int unsigned        short_side;
    int unsigned        long_side;
    ans.cmd    = cmd;
    ans.n      = n;
    ans.k      = k;
    ans.value  = '0;
    ans.status = ST_OK;
    acc        = 1;
    if (cmd == CMD_FACT) begin
      for (int unsigned i = 2; i <= n && ans.status == ST_OK; i++) begin
        prod = {{VALUE_W{1'b0}}, acc} * WIDE_W'(i);
        if (prod[WIDE_W-1:VALUE_W] != '0) ans.status = ST_OVERFLOW;
        else acc = prod[VALUE_W-1:0];
      end
    end else if (k > n) begin
      ans.status = ST_INVALID;
    end else begin
      short_side = n - k;
      long_side  = k;
      if (short_side > long_side) begin
        short_side = k;
        long_side  = n - k;
      end
      // each partial value is itself a binomial, so the division is exact
      for (int unsigned i = 1; i <= short_side && ans.status == ST_OK; i++) begin
        prod = ({{VALUE_W{1'b0}}, acc} * WIDE_W'(long_side + i)) / WIDE_W'(i);
        if (prod[WIDE_W-1:VALUE_W] != '0) ans.status = ST_OVERFLOW;
        else acc = prod[VALUE_W-1:0];
      end
    end
    if (ans.status == ST_OK) ans.value = acc;
    return ans;
  endfunction

  // offer one request, record its answer once the transfer happens
  task automatic send_request(input logic cmd, input logic [ARG_W-1:0] n,
                              input logic [ARG_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= cmd;
    req_ch.n     <= n;
    req_ch.k     <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_answers.push_back(predict_answer(cmd, n, k));
  endtask

  task automatic stop_sending();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_answers();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // factorial edges: trivial n, last fitting n, first overflowing n, k ignored
  task automatic test_factorial_corners();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(CMD_FACT, 8'd0, 8'd0);
    send_request(CMD_FACT, 8'd1, 8'd255);
    send_request(CMD_FACT, 8'd2, 8'd0);
    send_request(CMD_FACT, 8'd5, 8'd170);
    send_request(CMD_FACT, 8'd20, 8'd255);
    send_request(CMD_FACT, 8'd21, 8'd0);
    send_request(CMD_FACT, 8'd255, 8'd255);
    stop_sending();
    wait_for_answers();
  endtask

  // binomial edges: k at 0 or n, the swap of k and n-k, fit and overflow limits
  task automatic test_binomial_corners();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    send_request(CMD_BINOM, 8'd0, 8'd0);
    send_request(CMD_BINOM, 8'd5, 8'd0);
    send_request(CMD_BINOM, 8'd5, 8'd5);
    send_request(CMD_BINOM, 8'd255, 8'd0);
    send_request(CMD_BINOM, 8'd255, 8'd255);
    send_request(CMD_BINOM, 8'd255, 8'd1);
    send_request(CMD_BINOM, 8'd255, 8'd254);
    send_request(CMD_BINOM, 8'd10, 8'd3);
    send_request(CMD_BINOM, 8'd10, 8'd7);
    send_request(CMD_BINOM, 8'd67, 8'd33);
    send_request(CMD_BINOM, 8'd68, 8'd34);
    send_request(CMD_BINOM, 8'd255, 8'd127);
    stop_sending();
    wait_for_answers();
  endtask

  // k above n
  task automatic test_invalid_args();
    send_request(CMD_BINOM, 8'd0, 8'd1);
    send_request(CMD_BINOM, 8'd254, 8'd255);
    send_request(CMD_BINOM, 8'd0, 8'd255);
    stop_sending();
    wait_for_answers();
  endtask

  // random mix under one idling setting
  task automatic test_random_traffic(input int unsigned count, input int unsigned send_idle,
                                     input int unsigned recv_stall);
    logic [ARG_W-1:0] n;
    logic [ARG_W-1:0] k;
    int unsigned      pick;
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // well-formed binomial, mostly in the range where long loops still fit
        n = ($urandom_range(3) == 0) ? ARG_W'($urandom_range(255)) : ARG_W'($urandom_range(72));
        k = ARG_W'($urandom_range(n));
        send_request(CMD_BINOM, n, k);
      end else if (pick < 65) begin
        n = ($urandom_range(3) == 0) ? ARG_W'($urandom_range(255)) : ARG_W'($urandom_range(24));
        send_request(CMD_FACT, n, ARG_W'($urandom_range(255)));
      end else if (pick < 80) begin
        n = ARG_W'($urandom_range(254));
        k = ARG_W'($urandom_range(255, n + 1));
        send_request(CMD_BINOM, n, k);
      end else begin
        send_request(1'($urandom_range(1)), ARG_W'($urandom_range(255)),
                     ARG_W'($urandom_range(255)));
      end
    end
    stop_sending();
    wait_for_answers();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_result_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holds_asked <= holds_asked + 1;
    send_request(CMD_BINOM, 8'd30, 8'd4);
    send_request(CMD_FACT, 8'd6, 8'd0);
    send_request(CMD_BINOM, 8'd3, 8'd9);
    send_request(CMD_BINOM, 8'd40, 8'd38);
    send_request(CMD_FACT, 8'd1, 8'd0);
    send_request(CMD_BINOM, 8'd12, 8'd6);
    stop_sending();
    wait_for_answers();
  endtask

  // receiver ready: long hold when asked, random stalls otherwise
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each result transfer with the oldest pending answer
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result value %0d status %0d", $time, rsp_ch.value,
                 rsp_ch.status);
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (rsp_ch.value !== oldest_answer.value || rsp_ch.status !== oldest_answer.status)
        begin
          mismatch_count++;
          $display("%0t: cmd %0d n %0d k %0d expected value %0d status %s, got value %0d status %0d",
                   $time, oldest_answer.cmd, oldest_answer.n, oldest_answer.k,
                   oldest_answer.value, oldest_answer.status.name(), rsp_ch.value,
                   rsp_ch.status);
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd   <= CMD_FACT;
    req_ch.n     <= '0;
    req_ch.k     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_factorial_corners();
    test_binomial_corners();
    test_invalid_args();
    test_random_traffic(20, 0, 0);
    test_random_traffic(20, 72, 0);
    test_random_traffic(20, 0, 72);
    test_random_traffic(20, 6, 6);
    test_result_backpressure();

    // let any stray result show up before the verdict
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
